// File: sv/ssm_pkg.sv
`default_nettype none
package ssm_pkg;

    localparam int MAX_LEN      = 1024;
    localparam int PRICE_WIDTH  = 16;
    localparam int PRICE_PORT_W = 16;
    localparam int IDX_W        = $clog2(MAX_LEN);
    localparam int CNT_W        = $clog2(MAX_LEN + 1);

    typedef struct packed {
        logic [PRICE_WIDTH-1:0] price;
        logic [IDX_W-1:0]       idx;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

endpackage
`default_nettype wire

// File: sv/ssm_if.sv
`default_nettype none
interface ssm_in_if;
    logic                             valid;
    logic                             ready;
    logic [ssm_pkg::PRICE_PORT_W-1:0] price;
    logic                             first;

    modport source (output valid, output price, output first, input ready);
    modport sink   (input valid, input price, input first, output ready);
endinterface

interface ssm_out_if;
    logic                      valid;
    logic                      ready;
    logic [ssm_pkg::CNT_W-1:0] span;
    logic                      overflow;

    modport source (output valid, output span, output overflow, input ready);
    modport sink   (input valid, input span, input overflow, output ready);
endinterface
`default_nettype wire

// File: sv/stock_span_monotonic_stack.sv
// Channel  Dir  Payload           Handshake
// i_in     in   price, first      valid/ready
// o_out    out  span, overflow    valid/ready
//
// Each word: an accept step, then pops at one pop per cycle through the cell row,
// then a finishing step. Pops never outnumber pushes.
// A new word is taken only when the previous one is finished; a finished
// result waits in the output register while the next word is taken.
// The last cycle of a word stalls while the output register holds an untaken word.
// Reset clears stack depth, item index and valid; cell contents are not reset.
`default_nettype none
module stock_span_monotonic_stack (
    input  wire              i_clk,
    input  wire              i_rst_n,
    ssm_in_if.sink           i_in,
    ssm_out_if.source        o_out
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_POP
    } t_state;

    t_state                          r_state;
    logic [ssm_pkg::PRICE_WIDTH-1:0] r_price;
    logic [ssm_pkg::CNT_W-1:0]       r_count;
    logic [ssm_pkg::CNT_W-1:0]       r_index;
    logic                            r_out_valid;
    logic [ssm_pkg::CNT_W-1:0]       r_span;
    logic                            r_ovf;

    ssm_pkg::t_stk_ctl w_ctl;
    ssm_pkg::t_entry   w_push;
    ssm_pkg::t_entry   w_top;
    logic              w_accept;
    logic              w_out_free;
    logic              w_ovf;
    logic              w_pop;
    logic              w_done;
    logic [ssm_pkg::CNT_W-1:0] w_span;

    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_ovf      = (r_index >= ssm_pkg::CNT_W'(ssm_pkg::MAX_LEN));
    assign w_pop      = (r_state == S_POP) && !w_ovf && (r_count != '0)
                        && (w_top.price <= r_price);
    assign w_done     = (r_state == S_POP) && !w_pop && w_out_free;
    assign w_span     = (r_count == '0) ? (r_index + ssm_pkg::CNT_W'(1))
                        : (r_index - ssm_pkg::CNT_W'(w_top.idx));

    assign w_push.price = r_price;
    assign w_push.idx   = r_index[ssm_pkg::IDX_W-1:0];
    assign w_ctl.pop    = w_pop;
    assign w_ctl.push   = w_done && !w_ovf
                          && (r_count < ssm_pkg::CNT_W'(ssm_pkg::MAX_LEN));

    ssm_stack u_stack (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_push (w_push),
        .o_top  (w_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_index     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_price <= i_in.price[ssm_pkg::PRICE_WIDTH-1:0];
                        if (i_in.first) begin
                            r_count <= '0;
                            r_index <= '0;
                        end
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    if (w_pop) begin
                        r_count <= r_count - ssm_pkg::CNT_W'(1);
                    end else if (w_done) begin
                        r_state <= S_IDLE;
                        if (w_ovf) begin
                            r_span <= '0;
                            r_ovf  <= 1'b1;
                        end else begin
                            r_span  <= w_span;
                            r_ovf   <= 1'b0;
                            r_index <= r_index + ssm_pkg::CNT_W'(1);
                            if (w_ctl.push) begin
                                r_count <= r_count + ssm_pkg::CNT_W'(1);
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.span     = r_span;
    assign o_out.overflow = r_ovf;

    a_count_le_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_index)
        else $error("stack depth above item index");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= ssm_pkg::CNT_W'(ssm_pkg::MAX_LEN))
        else $error("item index beyond sequence limit");

    a_ovf_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_ovf |-> r_span == '0)
        else $error("overflow word with nonzero span");

    a_no_pop_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.pop && w_ctl.push))
        else $error("push and pop in one cycle");

    a_accept_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_POP)
        else $error("accepted word not processed");

endmodule
`default_nettype wire

// File: sv/ssm_cell.sv
`default_nettype none
module ssm_cell (
    input  wire                   i_clk,
    input  wire ssm_pkg::t_stk_ctl i_ctl,
    input  wire ssm_pkg::t_entry  i_above,
    input  wire ssm_pkg::t_entry  i_below,
    output ssm_pkg::t_entry       o_q
);

    ssm_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_q <= i_above;
        end else if (i_ctl.pop) begin
            r_q <= i_below;
        end
    end

    assign o_q = r_q;

endmodule
`default_nettype wire

// File: sv/ssm_stack.sv
`default_nettype none
module ssm_stack (
    input  wire                   i_clk,
    input  wire ssm_pkg::t_stk_ctl i_ctl,
    input  wire ssm_pkg::t_entry  i_push,
    output ssm_pkg::t_entry       o_top
);

    ssm_pkg::t_entry w_q [ssm_pkg::MAX_LEN];

    for (genvar g = 0; g < ssm_pkg::MAX_LEN; g++) begin : g_cell
        ssm_pkg::t_entry w_above;
        ssm_pkg::t_entry w_below;

        if (g == 0) begin : g_head
            assign w_above = i_push;
        end else begin : g_body
            assign w_above = w_q[g-1];
        end

        if (g == ssm_pkg::MAX_LEN - 1) begin : g_tail
            assign w_below = '0;
        end else begin : g_mid
            assign w_below = w_q[g+1];
        end

        ssm_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_above (w_above),
            .i_below (w_below),
            .o_q     (w_q[g])
        );
    end

    assign o_top = w_q[0];

endmodule
`default_nettype wire
